// ----- design/pcpc_pkg.sv -----
// Package: shared types and constants of the pulse charge phase controller.
`timescale 1ns / 1ps

package pcpc_pkg;

    // Default sizing
    localparam int BATTERY_COUNT_DEF = 3;
    localparam int SUM_WIDTH_DEF     = 48;

    // Fixed field widths
    localparam int CUR_W      = 16;
    localparam int TICK_W     = 24;
    localparam int CUM_W      = 32;
    localparam int FC_W       = 15;
    localparam int AVG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Phase codes
    localparam logic [1:0] PH_BULK  = 2'd0;
    localparam logic [1:0] PH_REST  = 2'd1;
    localparam logic [1:0] PH_FLOAT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_CUR  = 2'd2;

    // Register reset values
    localparam logic [TICK_W-1:0] MIN_OFF_RST    = 24'd60;
    localparam logic [CUM_W-1:0]  REST_LIMIT_RST = 32'd3600;
    localparam logic [FC_W-1:0]   FLOAT_CUR_RST  = 15'd256;

    typedef struct packed {
        logic signed [CUR_W-1:0] current_battery_a;
        logic signed [CUR_W-1:0] current_battery_b;
        logic signed [CUR_W-1:0] current_battery_c;
        logic [1:0]              battery_on_charge;
        logic [15:0]             charge_voltage;
        logic [15:0]             gassing_limit;
    } tick_word_t;

    typedef struct packed {
        logic [1:0]              phase_battery_a;
        logic [1:0]              phase_battery_b;
        logic [1:0]              phase_battery_c;
        logic [1:0]              soc_full_battery;
        logic signed [AVG_W-1:0] cycle_average;
    } result_word_t;

endpackage

// ----- design/pulse_charge_phase_controller.sv -----
// Top level: pulse charge phase controller with a shared restoring divider.
`timescale 1ns / 1ps

// Channel   Signals                               Direction  Word
// tick      tick_valid / tick_ready / tick_word   in         one charger tick
// result    result_valid / result_ready / ...     out        phases, full flag, average
// cfg       cfg_valid / cfg_ready / cfg_index ... in         one register write
//
// Sequence: after a tick is accepted, each battery entry is updated in turn (S_UPD),
// then the selected one is checked (S_CHECK); when a charge cycle closes through the
// divider (S_DIV, one quotient bit a cycle) the average is signed and clamped (S_SIGN)
// before S_FIN raises result_valid. The next tick can be taken as result_valid rises.
// Reset: asynchronous, active low; all phases bulk, counters and sums zero.
// Stalls: a result still held by result_ready low when the next tick reaches its
// final step keeps the block there until the held word is taken.
// cfg_ready is always high; writes land in the next cycle.

module pulse_charge_phase_controller #(
    parameter int BATTERY_COUNT = pcpc_pkg::BATTERY_COUNT_DEF,
    parameter int SUM_WIDTH     = pcpc_pkg::SUM_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_ready,
    input  pcpc_pkg::tick_word_t             tick_word,
    output logic                             result_valid,
    input  logic                             result_ready,
    output pcpc_pkg::result_word_t           result_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pcpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (BATTERY_COUNT > 1) ? $clog2(BATTERY_COUNT) : 1;
    localparam int CNT_W = $clog2(SUM_WIDTH + 1);
    localparam int TICK_W = pcpc_pkg::TICK_W;
    localparam int CUM_W  = pcpc_pkg::CUM_W;
    localparam int FC_W   = pcpc_pkg::FC_W;
    localparam int AVG_W  = pcpc_pkg::AVG_W;
    localparam int CUR_W  = pcpc_pkg::CUR_W;
    localparam int TOT_W  = TICK_W + 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPD   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
    localparam logic [CUM_W-1:0]  CUM_MAX  = {CUM_W{1'b1}};

    // Control
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             out_valid_reg, out_valid_next;

    // Configuration
    logic [TICK_W-1:0] min_off_reg;
    logic [CUM_W-1:0]  rest_limit_reg;
    logic [FC_W-1:0]   float_cur_reg;

    // Per-battery state, one read and one write port at ptr_reg; phase_reg is also read per battery for the result
    logic [1:0]                  phase_reg  [BATTERY_COUNT];
    logic [TICK_W-1:0]           rest_reg   [BATTERY_COUNT];
    logic [TICK_W-1:0]           charge_reg [BATTERY_COUNT];
    logic [CUM_W-1:0]            cum_reg    [BATTERY_COUNT];
    logic signed [SUM_WIDTH-1:0] sum_reg    [BATTERY_COUNT];

    // Entry write
    logic                        ent_we;
    logic [1:0]                  ent_phase_next;
    logic [TICK_W-1:0]           ent_rest_next;
    logic [TICK_W-1:0]           ent_charge_next;
    logic [CUM_W-1:0]            ent_cum_next;
    logic signed [SUM_WIDTH-1:0] ent_sum_next;

    // Working payload
    pcpc_pkg::tick_word_t   tick_reg;
    pcpc_pkg::result_word_t out_word_reg, out_word_next;
    logic                   close_reg, close_next;
    logic                   neg_reg, neg_next;
    logic signed [AVG_W-1:0] avg_reg, avg_next;
    logic [SUM_WIDTH-1:0]   dvd_reg, dvd_next;
    logic [TOT_W-1:0]       rem_reg, rem_next;
    logic [TOT_W-1:0]       divisor_reg, divisor_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // Entry read
    logic [1:0]                  cur_phase;
    logic [TICK_W-1:0]           cur_rest;
    logic [TICK_W-1:0]           cur_charge;
    logic [CUM_W-1:0]            cur_cum;
    logic signed [SUM_WIDTH-1:0] cur_sum;
    logic signed [CUR_W-1:0]     cur_in_arr [BATTERY_COUNT];

    // Datapath helpers
    logic                    sel_ok;
    logic [IDX_W-1:0]        sel_idx;
    logic [1:0]              sel_m1;
    logic [TICK_W-1:0]       rest_inc;
    logic [TICK_W-1:0]       charge_inc;
    logic [SUM_WIDTH:0]      sum_wide;
    logic [SUM_WIDTH-1:0]    sum_sat;
    logic [SUM_WIDTH-1:0]    sum_mag;
    logic [TOT_W-1:0]        total;
    logic [TOT_W:0]          cand;
    logic [TOT_W:0]          diff;
    logic                    q_bit;
    logic [CUM_W:0]          cum_sum;
    logic [CUM_W-1:0]        cum_sat;
    logic [AVG_W:0]          neg_avg;
    logic                    go_float;
    logic                    fin_go;
    logic [1:0]              ph_out [3];

    assign cur_phase  = phase_reg[ptr_reg];
    assign cur_rest   = rest_reg[ptr_reg];
    assign cur_charge = charge_reg[ptr_reg];
    assign cur_cum    = cum_reg[ptr_reg];
    assign cur_sum    = sum_reg[ptr_reg];

    always_comb
    begin
        for (int i = 0; i < BATTERY_COUNT; i++)
        begin
            if (i == 0)
                cur_in_arr[i] = tick_reg.current_battery_a;
            else if (i == 1)
                cur_in_arr[i] = tick_reg.current_battery_b;
            else
                cur_in_arr[i] = tick_reg.current_battery_c;
        end
    end

    assign sel_ok  = (tick_reg.battery_on_charge != 2'd0) &&
                     (int'(tick_reg.battery_on_charge) <= BATTERY_COUNT);
    assign sel_m1  = tick_reg.battery_on_charge - 2'd1;
    assign sel_idx = sel_ok ? sel_m1[IDX_W-1:0] : '0;

    // Tick counters saturate at all ones
    assign rest_inc   = (cur_rest != TICK_MAX) ? cur_rest + 1'b1 : cur_rest;
    assign charge_inc = (cur_charge != TICK_MAX) ? cur_charge + 1'b1 : cur_charge;

    // Saturating accumulate of this battery's current
    assign sum_wide = {cur_sum[SUM_WIDTH-1], cur_sum} +
                      {{(SUM_WIDTH - CUR_W + 1){cur_in_arr[ptr_reg][CUR_W-1]}},
                       cur_in_arr[ptr_reg]};
    assign sum_sat  = (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) ?
                      (sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                           : {1'b0, {(SUM_WIDTH-1){1'b1}}})
                      : sum_wide[SUM_WIDTH-1:0];

    assign sum_mag = cur_sum[SUM_WIDTH-1] ? ({SUM_WIDTH{1'b0}} - $unsigned(cur_sum))
                                          : $unsigned(cur_sum);
    assign total   = {1'b0, cur_rest} + {1'b0, cur_charge};

    // Restoring divider step
    assign cand  = {rem_reg, dvd_reg[SUM_WIDTH-1]};
    assign diff  = cand - {1'b0, divisor_reg};
    assign q_bit = (cand >= {1'b0, divisor_reg});

    // Cycle close: cumulated rest and float decision
    assign cum_sum  = {1'b0, cur_cum} + {{(CUM_W - TICK_W + 1){1'b0}}, cur_rest};
    assign cum_sat  = cum_sum[CUM_W] ? CUM_MAX : cum_sum[CUM_W-1:0];
    assign neg_avg  = {(AVG_W+1){1'b0}} - {avg_reg[AVG_W-1], avg_reg};
    assign go_float = ($signed(neg_avg) < $signed({2'b00, float_cur_reg})) ||
                      (cum_sat > rest_limit_reg);

    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        close_next      = close_reg;
        neg_next        = neg_reg;
        avg_next        = avg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        cnt_next        = cnt_reg;
        ent_we          = 1'b0;
        ent_phase_next  = cur_phase;
        ent_rest_next   = cur_rest;
        ent_charge_next = cur_charge;
        ent_cum_next    = cur_cum;
        ent_sum_next    = cur_sum;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_valid)
                begin
                    state_next = S_UPD;
                    ptr_next   = '0;
                end
            end
            S_UPD:
            begin
                ent_we       = 1'b1;
                ent_sum_next = sum_sat;
                if (cur_phase == pcpc_pkg::PH_REST)
                begin
                    ent_rest_next = rest_inc;
                    if (rest_inc > min_off_reg)
                        ent_phase_next = pcpc_pkg::PH_BULK;
                end
                else if (cur_phase == pcpc_pkg::PH_BULK)
                begin
                    ent_charge_next = charge_inc;
                end
                if (ptr_reg == IDX_W'(BATTERY_COUNT - 1))
                begin
                    ptr_next   = sel_idx;
                    state_next = S_CHECK;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                close_next = sel_ok && (cur_phase == pcpc_pkg::PH_BULK) &&
                             (tick_reg.charge_voltage > tick_reg.gassing_limit);
                state_next = S_FIN;
                avg_next   = AVG_W'(0) - {1'b0, float_cur_reg};
                if (close_next && (total != '0) && (cur_charge < min_off_reg))
                begin
                    neg_next     = cur_sum[SUM_WIDTH-1];
                    dvd_next     = sum_mag;
                    rem_next     = '0;
                    divisor_next = total;
                    cnt_next     = CNT_W'(SUM_WIDTH);
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = q_bit ? diff[TOT_W-1:0] : cand[TOT_W-1:0];
                dvd_next = {dvd_reg[SUM_WIDTH-2:0], q_bit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = S_SIGN;
            end
            S_SIGN:
            begin
                // quotient magnitude in dvd_reg; apply sign and clamp to 16 bits
                if (neg_reg)
                    avg_next = (dvd_reg > SUM_WIDTH'(32768)) ? AVG_W'(16'h8000)
                                                             : AVG_W'(0) - dvd_reg[AVG_W-1:0];
                else
                    avg_next = (dvd_reg > SUM_WIDTH'(32767)) ? AVG_W'(16'h7FFF)
                                                             : dvd_reg[AVG_W-1:0];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next = S_IDLE;
                    if (close_reg)
                    begin
                        ent_we          = 1'b1;
                        ent_phase_next  = go_float ? pcpc_pkg::PH_FLOAT : pcpc_pkg::PH_REST;
                        ent_rest_next   = '0;
                        ent_charge_next = '0;
                        ent_sum_next    = '0;
                        ent_cum_next    = go_float ? '0 : cum_sat;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Phases seen on the result: the closing battery takes its new phase
    for (genvar g = 0; g < 3; g++)
    begin : g_ph
        if (g < BATTERY_COUNT)
        begin : g_used
            assign ph_out[g] = (close_reg && (ptr_reg == IDX_W'(g))) ? ent_phase_next
                                                                     : phase_reg[g];
        end
        else
        begin : g_unused
            assign ph_out[g] = pcpc_pkg::PH_BULK;
        end
    end

    always_comb
    begin
        out_word_next                  = out_word_reg;
        out_valid_next                 = out_valid_reg && !result_ready;
        if (fin_go)
        begin
            out_valid_next                 = 1'b1;
            out_word_next.phase_battery_a  = ph_out[0];
            out_word_next.phase_battery_b  = ph_out[1];
            out_word_next.phase_battery_c  = ph_out[2];
            out_word_next.soc_full_battery = (close_reg && go_float) ?
                                             tick_reg.battery_on_charge : 2'd0;
            out_word_next.cycle_average    = close_reg ? avg_reg : '0;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ptr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            min_off_reg    <= pcpc_pkg::MIN_OFF_RST;
            rest_limit_reg <= pcpc_pkg::REST_LIMIT_RST;
            float_cur_reg  <= pcpc_pkg::FLOAT_CUR_RST;
            for (int i = 0; i < BATTERY_COUNT; i++)
            begin
                phase_reg[i]  <= pcpc_pkg::PH_BULK;
                rest_reg[i]   <= '0;
                charge_reg[i] <= '0;
                cum_reg[i]    <= '0;
                sum_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (ent_we)
            begin
                phase_reg[ptr_reg]  <= ent_phase_next;
                rest_reg[ptr_reg]   <= ent_rest_next;
                charge_reg[ptr_reg] <= ent_charge_next;
                cum_reg[ptr_reg]    <= ent_cum_next;
                sum_reg[ptr_reg]    <= ent_sum_next;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pcpc_pkg::CFG_MIN_OFF:    min_off_reg    <= cfg_data[TICK_W-1:0];
                    pcpc_pkg::CFG_REST_LIMIT: rest_limit_reg <= cfg_data[CUM_W-1:0];
                    pcpc_pkg::CFG_FLOAT_CUR:  float_cur_reg  <= cfg_data[FC_W-1:0];
                    default:                  ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
            tick_reg <= tick_word;
        out_word_reg <= out_word_next;
        close_reg    <= close_next;
        neg_reg      <= neg_next;
        avg_reg      <= avg_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        cnt_reg      <= cnt_next;
    end

    assign tick_ready   = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

// ----- design/pcpc_checker.sv -----
// Checker: port-level assertions of the phase controller, bound to the top level.
`timescale 1ns / 1ps

module pcpc_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   tick_valid,
    input logic                   tick_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input pcpc_pkg::result_word_t result_word
);

    // float is never left: remember which batteries have shown it
    logic [2:0] float_seen_reg, float_seen_next;

    always_comb
    begin
        float_seen_next = float_seen_reg;
        if (result_valid && result_ready)
        begin
            float_seen_next[0] = float_seen_reg[0] ||
                                 (result_word.phase_battery_a == pcpc_pkg::PH_FLOAT);
            float_seen_next[1] = float_seen_reg[1] ||
                                 (result_word.phase_battery_b == pcpc_pkg::PH_FLOAT);
            float_seen_next[2] = float_seen_reg[2] ||
                                 (result_word.phase_battery_c == pcpc_pkg::PH_FLOAT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            float_seen_reg <= '0;
        else
            float_seen_reg <= float_seen_next;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_word))
        else $error("result word dropped or changed while stalled");

    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick taken while previous one still in work");

    a_full_is_float: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            !((result_word.soc_full_battery == 2'd1 &&
               result_word.phase_battery_a != pcpc_pkg::PH_FLOAT) ||
              (result_word.soc_full_battery == 2'd2 &&
               result_word.phase_battery_b != pcpc_pkg::PH_FLOAT) ||
              (result_word.soc_full_battery == 2'd3 &&
               result_word.phase_battery_c != pcpc_pkg::PH_FLOAT)))
        else $error("full flag on a battery not in float");

    a_float_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            !((float_seen_reg[0] && result_word.phase_battery_a != pcpc_pkg::PH_FLOAT) ||
              (float_seen_reg[1] && result_word.phase_battery_b != pcpc_pkg::PH_FLOAT) ||
              (float_seen_reg[2] && result_word.phase_battery_c != pcpc_pkg::PH_FLOAT)))
        else $error("battery left float");

endmodule

bind pulse_charge_phase_controller pcpc_checker u_pcpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
);
